@@ hdl/csa_pkg.sv @@
// Shared types, constants and sample arithmetic for the coherent scan averager.
package csa_pkg;

  localparam int DATA_W      = 32;
  localparam int HALF_W      = 16;
  localparam int STRIP_SHIFT = 2;
  localparam int STRIP_W     = 12;
  localparam int IDX_W       = 12;
  localparam int WIDX_W      = 11;
  localparam int DIV_W       = 16;
  localparam int DIV_STEPS   = DATA_W;

  typedef enum logic {
    OP_ACCUMULATE = 1'b0,
    OP_READ       = 1'b1
  } op_t;

  typedef enum logic {
    REG_SCAN_COUNT = 1'b0,
    REG_STRIP_MODE = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] mag;
  } div_req_t;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] quot;
  } div_resp_t;

  function automatic logic [HALF_W-1:0] extract_sample(logic [HALF_W-1:0] half, logic strip);
    return strip ? HALF_W'(half[STRIP_SHIFT +: STRIP_W]) : half;
  endfunction

  function automatic logic [DATA_W-1:0] update_acc(logic [DATA_W-1:0] acc,
                                                  logic [HALF_W-1:0] sample,
                                                  logic sub, logic first);
    logic [DATA_W-1:0] signed_sample;
    signed_sample = sub ? (DATA_W'(0) - DATA_W'(sample)) : DATA_W'(sample);
    return first ? signed_sample : (acc + signed_sample);
  endfunction

endpackage

@@ hdl/csa_bank.sv @@
// One accumulator bank: synchronous memory with one write and one registered read port.
module csa_bank #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                         clk,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [csa_pkg::DATA_W-1:0]   rdata,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [csa_pkg::DATA_W-1:0]   wdata
);

  logic [csa_pkg::DATA_W-1:0] mem [0:DEPTH-1];

  // A read and a write to the same address in one cycle returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/csa_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, unsigned magnitude by scan count.
module csa_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [csa_pkg::DIV_W-1:0]  divisor,
  input  csa_pkg::div_req_t          req,
  output csa_pkg::div_resp_t         resp
);

  localparam int STEPS = csa_pkg::DIV_STEPS;
  localparam int DW    = csa_pkg::DATA_W;
  localparam int RW    = csa_pkg::DIV_W;

  logic                      st_valid [0:STEPS];
  logic                      st_neg   [0:STEPS];
  logic [csa_pkg::IDX_W-1:0] st_idx   [0:STEPS];
  logic [RW-1:0]             st_rem   [0:STEPS];
  logic [DW-1:0]             st_dq    [0:STEPS];

  // The partial remainder always stays below the divisor, so RW bits hold it.
  function automatic logic [RW+DW-1:0] div_step(logic [RW-1:0] rem, logic [DW-1:0] dq,
                                                logic [RW-1:0] d);
    logic [RW:0] trial;
    logic [RW:0] diff;
    logic        ge;
    trial = {rem, dq[DW-1]};
    diff  = trial - {1'b0, d};
    ge    = (trial >= {1'b0, d});
    return {(ge ? diff[RW-1:0] : trial[RW-1:0]), dq[DW-2:0], ge};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= STEPS; k++) begin
        st_valid[k] <= 1'b0;
      end
    end else if (advance) begin
      st_valid[0] <= req.valid;
      for (int k = 0; k < STEPS; k++) begin
        st_valid[k+1] <= st_valid[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st_neg[0] <= req.neg;
      st_idx[0] <= req.idx;
      st_rem[0] <= '0;
      st_dq[0]  <= req.mag;
      for (int k = 0; k < STEPS; k++) begin
        st_neg[k+1]                  <= st_neg[k];
        st_idx[k+1]                  <= st_idx[k];
        {st_rem[k+1], st_dq[k+1]}    <= div_step(st_rem[k], st_dq[k], divisor);
      end
    end
  end

  assign resp.valid = st_valid[STEPS];
  assign resp.neg   = st_neg[STEPS];
  assign resp.idx   = st_idx[STEPS];
  assign resp.quot  = st_dq[STEPS];

endmodule

@@ hdl/coherent_scan_averager.sv @@
// Top level of the coherent scan averager: register port, accumulate stage, readout path.
// Accepts one item per clock while item_stall is low. Accumulate items split each packed
// word over an even and an odd bank, read both entries, and write the updated sums back
// from the accumulate stage; a write-back register forwards the previous item's sums, so
// back-to-back hits on the same word are exact. A read item passes the registered bank read,
// the combinational forwarding and sign split, the divider input register, 32 stages of the
// bit-per-stage divider, and the output register. Input is stalled only while the output
// register holds an untaken result and the last divider stage holds another. ENTRIES must
// be a power of two; the accumulator memory has no reset, and no clearing pass is run.
module coherent_scan_averager #(
  parameter int ENTRIES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                operation,
  input  logic [10:0]         word_index,
  input  logic [31:0]         sample_word,
  input  logic                subtract,
  input  logic                first_scan,
  input  logic [11:0]         read_index,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [11:0]         entry_index,
  output logic signed [31:0]  average
);

  localparam int AW         = $clog2(ENTRIES);
  localparam int BAW        = (AW > 1) ? AW - 1 : 1;
  localparam int BANK_DEPTH = ENTRIES / 2;
  localparam int EXT_W      = (BAW + 1 > csa_pkg::IDX_W) ? BAW + 1 : csa_pkg::IDX_W;
  localparam int DW         = csa_pkg::DATA_W;
  localparam int HW         = csa_pkg::HALF_W;
  localparam logic [csa_pkg::IDX_W-1:0] IDX_MASK = csa_pkg::IDX_W'(ENTRIES - 1);

  // Configuration registers.
  logic [csa_pkg::DIV_W-1:0] scan_count;
  logic                      strip_mode;
  logic [csa_pkg::DIV_W-1:0] divisor;

  // Accumulate stage.
  logic                      s1_valid;
  csa_pkg::op_t              s1_op;
  logic [BAW-1:0]            s1_addr;
  logic                      s1_bank;
  logic [DW-1:0]             s1_word;
  logic                      s1_sub;
  logic                      s1_first;
  logic [csa_pkg::IDX_W-1:0] s1_idx;

  // Write-back forwarding.
  logic                      wb_valid;
  logic [BAW-1:0]            wb_addr;
  logic [DW-1:0]             wb_even;
  logic [DW-1:0]             wb_odd;

  logic                      advance;
  logic                      accept;
  logic [csa_pkg::IDX_W-1:0] ridx_wrapped;
  logic [EXT_W-1:0]          widx_ext;
  logic [EXT_W-1:0]          ridx_ext;
  logic [BAW-1:0]            wr_bank_addr;
  logic [BAW-1:0]            rd_bank_addr;
  logic [BAW-1:0]            mem_raddr;
  logic [DW-1:0]             even_rdata;
  logic [DW-1:0]             odd_rdata;
  logic                      fwd_hit;
  logic [DW-1:0]             even_acc;
  logic [DW-1:0]             odd_acc;
  logic [DW-1:0]             even_new;
  logic [DW-1:0]             odd_new;
  logic [DW-1:0]             rd_acc;
  logic                      s1_is_acc;
  logic                      wr_en;
  logic                      out_load;
  csa_pkg::div_req_t         div_req;
  csa_pkg::div_resp_t        div_resp;

  // Register port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_count <= csa_pkg::DIV_W'(1);
      strip_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (csa_pkg::reg_sel_t'(paddr[2]))
        csa_pkg::REG_SCAN_COUNT: scan_count <= pwdata[csa_pkg::DIV_W-1:0];
        csa_pkg::REG_STRIP_MODE: strip_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (csa_pkg::reg_sel_t'(paddr[2]))
      csa_pkg::REG_SCAN_COUNT: prdata = 32'(scan_count);
      csa_pkg::REG_STRIP_MODE: prdata = 32'(strip_mode);
      default:                 prdata = '0;
    endcase
  end

  // A zero scan count divides by one.
  assign divisor = (scan_count == '0) ? csa_pkg::DIV_W'(1) : scan_count;

  // The pipeline moves unless a finished result would collide with an untaken one.
  assign advance    = !(result_valid && result_stall) || !div_resp.valid;
  assign item_stall = !advance;
  assign accept     = item_valid && advance;

  // Address decode: entry 2*w lives in the even bank, 2*w+1 in the odd bank, both at w.
  assign ridx_wrapped = read_index & IDX_MASK;
  assign widx_ext     = EXT_W'(word_index);
  assign ridx_ext     = EXT_W'(ridx_wrapped);
  assign wr_bank_addr = (AW > 1) ? widx_ext[BAW-1:0] : '0;
  assign rd_bank_addr = (AW > 1) ? ridx_ext[BAW:1] : '0;
  assign mem_raddr    = (operation == csa_pkg::OP_READ) ? rd_bank_addr : wr_bank_addr;

  csa_bank #(.DEPTH(BANK_DEPTH), .AW(BAW)) u_even (
    .clk   (clk),
    .re    (advance),
    .raddr (mem_raddr),
    .rdata (even_rdata),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (even_new)
  );

  csa_bank #(.DEPTH(BANK_DEPTH), .AW(BAW)) u_odd (
    .clk   (clk),
    .re    (advance),
    .raddr (mem_raddr),
    .rdata (odd_rdata),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (odd_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= csa_pkg::op_t'(operation);
      s1_addr  <= mem_raddr;
      s1_bank  <= ridx_ext[0];
      s1_word  <= sample_word;
      s1_sub   <= subtract;
      s1_first <= first_scan;
      s1_idx   <= ridx_wrapped;
    end
  end

  // The bank read misses the write made at the same edge, so take it from the write-back copy.
  assign fwd_hit  = wb_valid && (wb_addr == s1_addr);
  assign even_acc = fwd_hit ? wb_even : even_rdata;
  assign odd_acc  = fwd_hit ? wb_odd : odd_rdata;

  assign even_new = csa_pkg::update_acc(even_acc,
                      csa_pkg::extract_sample(s1_word[HW-1:0], strip_mode), s1_sub, s1_first);
  assign odd_new  = csa_pkg::update_acc(odd_acc,
                      csa_pkg::extract_sample(s1_word[DW-1:HW], strip_mode), s1_sub, s1_first);

  assign s1_is_acc = s1_valid && (s1_op == csa_pkg::OP_ACCUMULATE);
  assign wr_en     = advance && s1_is_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (advance) begin
      wb_valid <= s1_is_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_addr <= s1_addr;
      wb_even <= even_new;
      wb_odd  <= odd_new;
    end
  end

  // Readout: split sign and magnitude ahead of the unsigned divider.
  assign rd_acc        = s1_bank ? odd_acc : even_acc;
  assign div_req.valid = s1_valid && (s1_op == csa_pkg::OP_READ);
  assign div_req.neg   = rd_acc[DW-1];
  assign div_req.idx   = s1_idx;
  assign div_req.mag   = rd_acc[DW-1] ? (DW'(0) - rd_acc) : rd_acc;

  csa_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .divisor (divisor),
    .req     (div_req),
    .resp    (div_resp)
  );

  // Output register.
  assign out_load = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= div_resp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && div_resp.valid) begin
      entry_index <= div_resp.idx;
      average     <= div_resp.neg ? $signed(DW'(0) - div_resp.quot) : $signed(div_resp.quot);
    end
  end

endmodule
